FILE: sv/ezhm_pkg.sv
// Shared constants, types and helper functions for the Euler pose to transform unit.
package ezhm_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int XW = 34;
   localparam int ZW = 35;
   localparam int PW = 48;

   localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
   localparam logic signed [XW-1:0] GAIN_Q30    = 34'sd652032874;
   localparam logic signed [15:0]   ONE_Q14     = 16'sd16384;

   typedef struct packed {
      logic signed [15:0] sy;
      logic signed [15:0] cy;
      logic signed [15:0] sp;
      logic signed [15:0] cp;
      logic signed [15:0] sr;
      logic signed [15:0] cr;
   } trig_type;

   function automatic logic signed [ZW-1:0] atan_step(input int i);
      logic signed [63:0] v;
      case (i)
         0:       v = 64'sd843314857;
         1:       v = 64'sd497837829;
         2:       v = 64'sd263043837;
         3:       v = 64'sd133525159;
         4:       v = 64'sd67021687;
         5:       v = 64'sd33543516;
         6:       v = 64'sd16775851;
         7:       v = 64'sd8388437;
         8:       v = 64'sd4194283;
         9:       v = 64'sd2097149;
         10:      v = 64'sd1048576;
         default: begin
            if (i > 30) v = 64'sd0;
            else v = 64'sd1 <<< (30 - i);
         end
      endcase
      return ZW'(v);
   endfunction

   function automatic logic signed [15:0] clamp14(input logic signed [PW-1:0] v);
      logic signed [15:0] r;
      if (v > PW'(ONE_Q14)) r = ONE_Q14;
      else if (v < -PW'(ONE_Q14)) r = -ONE_Q14;
      else r = v[15:0];
      return r;
   endfunction

endpackage

FILE: sv/euler_zyx_to_homogeneous_matrix_unit.sv
// Top level: Z-Y-X Euler pose to homogeneous transform, CORDIC then product pipeline.
// Throughput is one word per cycle; the whole pipeline advances unless a result is held
// by rsp_stall, in which case req_stall is raised in the same cycle.
// Synchronous active-high reset clears all valid bits; data registers are not reset.
module euler_zyx_to_homogeneous_matrix_unit import ezhm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_yaw,
   input  logic signed [15:0] req_pitch,
   input  logic signed [15:0] req_roll,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_r00,
   output logic signed [15:0] rsp_r01,
   output logic signed [15:0] rsp_r02,
   output logic signed [15:0] rsp_r10,
   output logic signed [15:0] rsp_r11,
   output logic signed [15:0] rsp_r12,
   output logic signed [15:0] rsp_r20,
   output logic signed [15:0] rsp_r21,
   output logic signed [15:0] rsp_r22,
   output logic signed [31:0] rsp_trans_x,
   output logic signed [31:0] rsp_trans_y,
   output logic signed [31:0] rsp_trans_z
);

   localparam int DLY = CORDIC_STEPS + 2;

   logic             advance;
   logic             trig_valid;
   trig_type         trig;
   logic [2:0][31:0] pos_ff [DLY];
   logic [2:0][31:0] trans_out;

   assign advance = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (advance) begin
         pos_ff[0] <= {req_pos_z, req_pos_y, req_pos_x};
         for (int i = 1; i < DLY; i++) begin
            pos_ff[i] <= pos_ff[i-1];
         end
      end
   end

   ezhm_sincos u_sincos (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .angle_in  ({req_roll, req_pitch, req_yaw}),
      .out_valid (trig_valid),
      .trig_out  (trig)
   );

   ezhm_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (trig_valid),
      .trig      (trig),
      .trans_in  (pos_ff[DLY-1]),
      .out_valid (rsp_valid),
      .r00       (rsp_r00),
      .r01       (rsp_r01),
      .r02       (rsp_r02),
      .r10       (rsp_r10),
      .r11       (rsp_r11),
      .r12       (rsp_r12),
      .r20       (rsp_r20),
      .r21       (rsp_r21),
      .r22       (rsp_r22),
      .trans_out (trans_out)
   );

   assign rsp_trans_x = trans_out[0];
   assign rsp_trans_y = trans_out[1];
   assign rsp_trans_z = trans_out[2];

   a_stall_source: assert property (@(posedge clock)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_diag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_r00 <= 16'sd16384 && rsp_r00 >= -16'sd16384
                     && rsp_r22 <= 16'sd16384 && rsp_r22 >= -16'sd16384))
      else $error("rotation entry outside unit range");

endmodule

FILE: sv/ezhm_sincos.sv
// Pipelined CORDIC that turns three angles into their sines and cosines.
module ezhm_sincos import ezhm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [2:0][15:0] angle_in,
   output logic             out_valid,
   output trig_type         trig_out
);

   logic signed [XW-1:0] x_ff [0:CORDIC_STEPS][3];
   logic signed [XW-1:0] y_ff [0:CORDIC_STEPS][3];
   logic signed [ZW-1:0] z_ff [0:CORDIC_STEPS][3];
   logic                 neg_ff [0:CORDIC_STEPS][3];
   logic                 valid_ff [0:CORDIC_STEPS];
   logic signed [15:0]   sin_ff [3];
   logic signed [15:0]   cos_ff [3];
   logic                 out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= in_valid;
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_fold
      logic signed [ZW-1:0] z_in;
      logic                 neg_in;
      always_comb begin
         z_in = ZW'($signed(angle_in[l])) <<< 17;
         neg_in = 1'b0;
         if (z_in > HALF_PI_Q30) begin
            z_in = z_in - PI_Q30;
            neg_in = 1'b1;
         end else if (z_in < -HALF_PI_Q30) begin
            z_in = z_in + PI_Q30;
            neg_in = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            x_ff[0][l] <= GAIN_Q30;
            y_ff[0][l] <= '0;
            z_ff[0][l] <= z_in;
            neg_ff[0][l] <= neg_in;
         end
      end
   end

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g+1] <= 1'b0;
         end else if (advance) begin
            valid_ff[g+1] <= valid_ff[g];
         end
      end
      for (genvar l = 0; l < 3; l++) begin : g_lane
         always_ff @(posedge clock) begin
            if (advance) begin
               neg_ff[g+1][l] <= neg_ff[g][l];
               if (z_ff[g][l] >= 0) begin
                  x_ff[g+1][l] <= x_ff[g][l] - (y_ff[g][l] >>> g);
                  y_ff[g+1][l] <= y_ff[g][l] + (x_ff[g][l] >>> g);
                  z_ff[g+1][l] <= z_ff[g][l] - atan_step(g);
               end else begin
                  x_ff[g+1][l] <= x_ff[g][l] + (y_ff[g][l] >>> g);
                  y_ff[g+1][l] <= y_ff[g][l] - (x_ff[g][l] >>> g);
                  z_ff[g+1][l] <= z_ff[g][l] + atan_step(g);
               end
            end
         end
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_round
      logic signed [PW-1:0] xs;
      logic signed [PW-1:0] ys;
      always_comb begin
         xs = PW'(x_ff[CORDIC_STEPS][l]);
         ys = PW'(y_ff[CORDIC_STEPS][l]);
         if (neg_ff[CORDIC_STEPS][l]) begin
            xs = -xs;
            ys = -ys;
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            cos_ff[l] <= clamp14((xs + PW'(32768)) >>> 16);
            sin_ff[l] <= clamp14((ys + PW'(32768)) >>> 16);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= valid_ff[CORDIC_STEPS];
      end
   end

   assign out_valid = out_valid_ff;
   assign trig_out.sy = sin_ff[0];
   assign trig_out.cy = cos_ff[0];
   assign trig_out.sp = sin_ff[1];
   assign trig_out.cp = cos_ff[1];
   assign trig_out.sr = sin_ff[2];
   assign trig_out.cr = cos_ff[2];

endmodule

FILE: sv/ezhm_matrix.sv
// Three-stage product and rounding pipeline that forms the rotation entries.
module ezhm_matrix import ezhm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  trig_type            trig,
   input  logic [2:0][31:0]    trans_in,
   output logic                out_valid,
   output logic signed [15:0]  r00,
   output logic signed [15:0]  r01,
   output logic signed [15:0]  r02,
   output logic signed [15:0]  r10,
   output logic signed [15:0]  r11,
   output logic signed [15:0]  r12,
   output logic signed [15:0]  r20,
   output logic signed [15:0]  r21,
   output logic signed [15:0]  r22,
   output logic [2:0][31:0]    trans_out
);

   logic signed [31:0] cpcy_ff, cpsy_ff, cpsr_ff, cpcr_ff, cysp_ff, crsy_ff;
   logic signed [31:0] srsy_ff, crcy_ff, spsr_ff, crsp_ff, cysr_ff;
   logic signed [15:0] sp1_ff, sr1_ff, sy1_ff;
   logic [2:0][31:0]   trans1_ff, trans2_ff, trans3_ff;
   logic               v1_ff, v2_ff, v3_ff;

   logic signed [PW-1:0] t01_ff, t02_ff, t11_ff, t12_ff;
   logic signed [PW-1:0] s01_ff, s02_ff, s11_ff, s12_ff;
   logic signed [15:0]   e00_ff, e10_ff, e20_ff, e21_ff, e22_ff;

   logic signed [15:0] o00_ff, o01_ff, o02_ff, o10_ff, o11_ff, o12_ff;
   logic signed [15:0] o20_ff, o21_ff, o22_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cpcy_ff <= trig.cp * trig.cy;
         cpsy_ff <= trig.cp * trig.sy;
         cpsr_ff <= trig.cp * trig.sr;
         cpcr_ff <= trig.cp * trig.cr;
         cysp_ff <= trig.cy * trig.sp;
         crsy_ff <= trig.cr * trig.sy;
         srsy_ff <= trig.sr * trig.sy;
         crcy_ff <= trig.cr * trig.cy;
         spsr_ff <= trig.sp * trig.sr;
         crsp_ff <= trig.cr * trig.sp;
         cysr_ff <= trig.cy * trig.sr;
         sp1_ff <= trig.sp;
         sr1_ff <= trig.sr;
         sy1_ff <= trig.sy;
         trans1_ff <= trans_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t01_ff <= PW'(cysp_ff) * PW'(sr1_ff);
         t02_ff <= PW'(crcy_ff) * PW'(sp1_ff);
         t11_ff <= PW'(spsr_ff) * PW'(sy1_ff);
         t12_ff <= PW'(crsp_ff) * PW'(sy1_ff);
         s01_ff <= PW'(crsy_ff) <<< 14;
         s02_ff <= PW'(srsy_ff) <<< 14;
         s11_ff <= PW'(crcy_ff) <<< 14;
         s12_ff <= PW'(cysr_ff) <<< 14;
         e00_ff <= clamp14((PW'(cpcy_ff) + PW'(8192)) >>> 14);
         e10_ff <= clamp14((PW'(cpsy_ff) + PW'(8192)) >>> 14);
         e21_ff <= clamp14((PW'(cpsr_ff) + PW'(8192)) >>> 14);
         e22_ff <= clamp14((PW'(cpcr_ff) + PW'(8192)) >>> 14);
         e20_ff <= clamp14(-PW'(sp1_ff));
         trans2_ff <= trans1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         o01_ff <= clamp14((t01_ff - s01_ff + PW'(134217728)) >>> 28);
         o02_ff <= clamp14((s02_ff + t02_ff + PW'(134217728)) >>> 28);
         o11_ff <= clamp14((s11_ff + t11_ff + PW'(134217728)) >>> 28);
         o12_ff <= clamp14((t12_ff - s12_ff + PW'(134217728)) >>> 28);
         o00_ff <= e00_ff;
         o10_ff <= e10_ff;
         o20_ff <= e20_ff;
         o21_ff <= e21_ff;
         o22_ff <= e22_ff;
         trans3_ff <= trans2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign r00 = o00_ff;
   assign r01 = o01_ff;
   assign r02 = o02_ff;
   assign r10 = o10_ff;
   assign r11 = o11_ff;
   assign r12 = o12_ff;
   assign r20 = o20_ff;
   assign r21 = o21_ff;
   assign r22 = o22_ff;
   assign trans_out = trans3_ff;

endmodule

FILE: verif/tb_top.sv
// Testbench for the Euler pose to transform unit: directed table, random poses, scoreboard.
module tb_top import ezhm_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [15:0] yaw, pitch, roll;
      logic signed [31:0] px, py, pz;
   } pose_type;

   typedef struct {
      logic signed [15:0] m [9];
      logic signed [31:0] tx, ty, tz;
   } xform_type;

   typedef struct {
      pose_type  p;
      bit        known;
      xform_type x;
   } row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [15:0] req_yaw = 0, req_pitch = 0, req_roll = 0;
   logic signed [31:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [15:0] rsp_r00, rsp_r01, rsp_r02, rsp_r10, rsp_r11, rsp_r12;
   logic signed [15:0] rsp_r20, rsp_r21, rsp_r22;
   logic signed [31:0] rsp_trans_x, rsp_trans_y, rsp_trans_z;

   xform_type expected_xforms [$];
   int        mismatches = 0;
   int        stall_left = 0;
   bit        quiet_tail = 0;
   bit        hold_long = 0;
   bit        stim_done = 0;

   always #5 clock = ~clock;

   euler_zyx_to_homogeneous_matrix_unit dut (.*);

   function automatic longint floor_shift(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint sat14(longint v);
      if (v > 16384) return 16384;
      if (v < -16384) return -16384;
      return v;
   endfunction

   function automatic longint arctan_q30(int i);
      longint head [11] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                            33543516, 16775851, 8388437, 4194283, 2097149, 1048576};
      if (i <= 10) return head[i];
      if (i > 30) return 0;
      return longint'(1) << (30 - i);
   endfunction

   function automatic void cordic_sin_cos(input logic signed [15:0] a, output longint s,
                                          output longint c);
      longint z, x, y, nx, ny;
      bit flip;
      z = longint'(a) * 131072;
      x = 652032874;
      y = 0;
      flip = 0;
      if (z > 1686629713) begin
         z -= 64'sd3373259426;
         flip = 1;
      end else if (z < -1686629713) begin
         z += 64'sd3373259426;
         flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         if (z >= 0) begin
            nx = x - floor_shift(y, i);
            ny = y + floor_shift(x, i);
            z -= arctan_q30(i);
         end else begin
            nx = x + floor_shift(y, i);
            ny = y - floor_shift(x, i);
            z += arctan_q30(i);
         end
         x = nx;
         y = ny;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = sat14(floor_shift(x + 32768, 16));
      s = sat14(floor_shift(y + 32768, 16));
   endfunction

   function automatic logic signed [15:0] q28(longint p);
      return 16'(sat14(floor_shift(p + 8192, 14)));
   endfunction

   function automatic logic signed [15:0] q42(longint p);
      return 16'(sat14(floor_shift(p + 134217728, 28)));
   endfunction

   function automatic xform_type pose_to_xform(pose_type p);
      xform_type r;
      longint sy, cy, sp, cp, sr, cr;
      cordic_sin_cos(p.yaw, sy, cy);
      cordic_sin_cos(p.pitch, sp, cp);
      cordic_sin_cos(p.roll, sr, cr);
      r.m[0] = q28(cp * cy);
      r.m[1] = q42(cy * sp * sr - cr * sy * 16384);
      r.m[2] = q42(sr * sy * 16384 + cr * cy * sp);
      r.m[3] = q28(cp * sy);
      r.m[4] = q42(cr * cy * 16384 + sp * sr * sy);
      r.m[5] = q42(cr * sp * sy - cy * sr * 16384);
      r.m[6] = 16'(sat14(-sp));
      r.m[7] = q28(cp * sr);
      r.m[8] = q28(cp * cr);
      r.tx = p.px;
      r.ty = p.py;
      r.tz = p.pz;
      return r;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   function automatic pose_type random_pose(bit wide);
      pose_type p;
      if (wide) begin
         p.yaw = 16'($urandom);
         p.pitch = 16'($urandom);
         p.roll = 16'($urandom);
      end else begin
         p.yaw = 16'($urandom_range(51472) - 25736);
         p.pitch = 16'($urandom_range(51472) - 25736);
         p.roll = 16'($urandom_range(51472) - 25736);
      end
      p.px = $urandom;
      p.py = $urandom;
      p.pz = $urandom;
      return p;
   endfunction

   task automatic offer(pose_type p);
      req_valid <= 1;
      req_yaw <= p.yaw;
      req_pitch <= p.pitch;
      req_roll <= p.roll;
      req_pos_x <= p.px;
      req_pos_y <= p.py;
      req_pos_z <= p.pz;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_word(pose_type p, bit known, xform_type x);
      int gap;
      if (!known) x = pose_to_xform(p);
      expected_xforms.push_back(x);
      offer(p);
      if (!quiet_tail && $urandom_range(5) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic row_type fixed_row(logic signed [15:0] y, logic signed [15:0] p,
                                         logic signed [15:0] r, logic signed [31:0] t);
      row_type w;
      w.p = '{y, p, r, t, ~t, -t};
      w.known = 0;
      return w;
   endfunction

   initial begin
      row_type dir [$];
      row_type w;
      pose_type p;
      w = fixed_row(0, 0, 0, 0);
      w.known = 1;
      w.x.m = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
      w.x.tx = 0;
      w.x.ty = -1;
      w.x.tz = 0;
      dir.push_back(w);
      dir.push_back(fixed_row(25736, 0, 0, 32'sh7fffffff));
      dir.push_back(fixed_row(-25736, 0, 0, 32'sh80000000));
      dir.push_back(fixed_row(0, 25736, 0, 1));
      dir.push_back(fixed_row(0, -25736, 0, -1));
      dir.push_back(fixed_row(0, 0, 25736, 32'sh00010000));
      dir.push_back(fixed_row(0, 0, -25736, 32'sh55555555));
      dir.push_back(fixed_row(12868, 12868, 12868, 32'shaaaaaaaa));
      dir.push_back(fixed_row(-12868, -12868, -12868, 7));
      dir.push_back(fixed_row(12869, -12869, 12870, 9));
      dir.push_back(fixed_row(16'sh7fff, 16'sh7fff, 16'sh7fff, 3));
      dir.push_back(fixed_row(16'sh8000, 16'sh8000, 16'sh8000, 5));
      dir.push_back(fixed_row(16'sh5555, 16'shaaaa, 16'sh0001, 11));
      dir.push_back(fixed_row(25736, 25736, 25736, 13));
      dir.push_back(fixed_row(-25736, -25736, -25736, 17));
      dir.push_back(fixed_row(6434, -6434, 19302, 19));

      repeat (3) @(posedge clock);
      reset <= 0;
      foreach (dir[i]) send_word(dir[i].p, dir[i].known, dir[i].x);
      for (int i = 0; i < 1880; i++) begin
         if (i == 300) hold_long = 1;
         if (i == 1700) quiet_tail = 1;
         p = random_pose($urandom_range(9) == 0);
         send_word(p, 0, w.x);
      end
      req_valid <= 0;
      stim_done = 1;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
         stall_left = 0;
      end else if (hold_long) begin
         rsp_stall <= 1;
      end else if (stall_left > 0 && !quiet_tail) begin
         rsp_stall <= 1;
         stall_left--;
      end else if (!quiet_tail && $urandom_range(7) == 0) begin
         rsp_stall <= 1;
         stall_left = $urandom_range(0, 9);
      end else begin
         rsp_stall <= 0;
      end
   end

   initial begin
      wait (hold_long);
      repeat (80) @(posedge clock);
      hold_long = 0;
   end

   always @(posedge clock) begin
      xform_type e;
      logic signed [15:0] got [9];
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_r00, rsp_r01, rsp_r02, rsp_r10, rsp_r11, rsp_r12,
                 rsp_r20, rsp_r21, rsp_r22};
         if (expected_xforms.size() == 0) begin
            report("unexpected word", 0, 0);
         end else begin
            e = expected_xforms.pop_front();
            foreach (got[k]) begin
               if (got[k] !== e.m[k]) report($sformatf("r%0d", k), got[k], e.m[k]);
            end
            if (rsp_trans_x !== e.tx) report("trans_x", rsp_trans_x, e.tx);
            if (rsp_trans_y !== e.ty) report("trans_y", rsp_trans_y, e.ty);
            if (rsp_trans_z !== e.tz) report("trans_z", rsp_trans_z, e.tz);
         end
      end
   end

   initial begin
      wait (stim_done);
      while (expected_xforms.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && expected_xforms.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("FAIL");
      $finish;
   end

endmodule

FILE: sim.f
sv/ezhm_pkg.sv
sv/ezhm_sincos.sv
sv/ezhm_matrix.sv
sv/euler_zyx_to_homogeneous_matrix_unit.sv
verif/tb_top.sv
